// ----- sv/bdil_pkg.sv -----
// Shared types and constants of the 3x3 binary dilation block.
// Used by the channel interfaces and the top level.
package bdil_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 12;
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int CFG_W  = 13;
    localparam int CIDX_W = 2;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [FW_W-1:0]  fwidth_t;
    typedef logic [FH_W-1:0]  fheight_t;
    typedef logic [CFG_W-1:0] cfg_data_t;
    typedef logic [CIDX_W-1:0] cfg_idx_t;

    // Register indexes of the configuration port.
    localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;
    localparam cfg_idx_t REG_ON_THRESHOLD = 2'd2;

    localparam fwidth_t  FRAME_WIDTH_RST  = 11'd640;
    localparam fheight_t FRAME_HEIGHT_RST = 13'd480;
    localparam pixel_t   THRESHOLD_RST    = 8'd127;
    localparam fwidth_t  WIDTH_LIMIT      = 11'd1024;
    localparam fheight_t HEIGHT_LIMIT     = 13'd4096;

    localparam pixel_t PIX_ON  = 8'd255;
    localparam pixel_t PIX_OFF = 8'd0;

    // Window bits: bits 2:0 column x, 5:3 column x-1, 8:6 column x-2;
    // inside a column bit 0 is row y, bit 1 row y-1, bit 2 row y-2.
    localparam logic [8:0] MASK_FULL      = 9'h1FF;
    localparam logic [8:0] MASK_RIGHT     = 9'h03F;
    localparam logic [8:0] MASK_BOTTOM    = 9'h0DB;
    localparam logic [8:0] MASK_CORNER    = 9'h01B;

endpackage

// ----- sv/bdil_if.sv -----
// Valid/ready channel interfaces for the pixel input and result output.
// Depend on bdil_pkg for the payload types.
interface bdil_in_if;
    logic             valid;
    logic             ready;
    bdil_pkg::pixel_t grey_value;

    modport source (output valid, output grey_value, input ready);
    modport sink   (input valid, input grey_value, output ready);
endinterface

interface bdil_out_if;
    logic             valid;
    logic             ready;
    bdil_pkg::pixel_t out_value;
    bdil_pkg::col_t   out_col;
    bdil_pkg::row_t   out_row;
    logic             run_last;

    modport source (output valid, output out_value, output out_col, output out_row,
                    output run_last, input ready);
    modport sink   (input valid, input out_value, input out_col, input out_row,
                    input run_last, output ready);
endinterface

// ----- sv/bdil_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; holds the two line stores of the dilation block.
module bdil_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- sv/binary_dilate_3x3.sv -----
// Top level of the streaming 3x3 binary dilation: threshold, line stores, window, results.
// Depends on bdil_pkg, the channel interfaces in bdil_if.sv and bdil_ram.
//
//   channel   dir  payload                                      handshake
//   pix_in    in   grey_value                                   valid/ready
//   pix_out   out  out_value, out_col, out_row, run_last        valid/ready
//   cfg       in   cfg_index, cfg_data                          cfg_we
//
// One pixel is accepted per cycle unless the window stage is held. A pixel causes zero to
// four results, delivered one per cycle from the result register while pix_out is ready,
// so the input stalls while a pixel has more than one result: at row ends after the first
// row and at pixels of the last row after its first column. A pixel reads the line store
// at its acceptance edge; its results then pass the window stage and the result register.
// Reset restores the register defaults and clears counters and window; the line stores are
// not cleared, since their reads are masked by the row position.
// A stall at pix_out holds the result register, then the window stage, then pix_in.
module binary_dilate_3x3 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  bdil_pkg::cfg_idx_t   cfg_index,
    input  bdil_pkg::cfg_data_t  cfg_data,
    bdil_in_if.sink              pix_in,
    bdil_out_if.source           pix_out
);
    import bdil_pkg::*;

    // Configuration.
    fwidth_t  frame_width_reg;
    fheight_t frame_height_reg;
    pixel_t   on_threshold_reg;

    // Input position counters.
    col_t col_count_reg, col_count_next;
    row_t row_count_reg, row_count_next;

    // Window stage (item waiting for its line store data).
    logic s1_valid_reg;
    logic s1_cur_reg;
    col_t s1_x_reg;
    row_t s1_y_reg;
    logic s1_last_col_reg;
    logic s1_last_row_reg;
    logic byp_valid_reg;
    logic [1:0] byp_data_reg;
    logic [8:0] window_reg, window_next;

    // Result register: up to four results of one pixel.
    logic [3:0] pend_reg, pend_next;
    logic [3:0] res_on_reg;
    col_t res_x_reg;
    row_t res_y_reg;

    fwidth_t  w_eff;
    fheight_t h_eff;
    col_t     x_in;
    row_t     y_in;
    logic     last_col_in, last_row_in;
    logic     in_fire, s1_adv, set_free, out_fire;
    logic [1:0] rd_data, wr_data, line_bits;
    logic [2:0] col_bits;
    logic [3:0] new_mask, new_on, low_bit;
    logic [1:0] sel;

    // Effective frame size and current position.
    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = fwidth_t'(1);
        else if (frame_width_reg > WIDTH_LIMIT)
            w_eff = WIDTH_LIMIT;
        else
            w_eff = frame_width_reg;

        if (frame_height_reg == '0)
            h_eff = fheight_t'(1);
        else if (frame_height_reg > HEIGHT_LIMIT)
            h_eff = HEIGHT_LIMIT;
        else
            h_eff = frame_height_reg;
    end

    assign x_in = ({1'b0, col_count_reg} < w_eff) ? col_count_reg : COL_W'(w_eff - 1'b1);
    assign y_in = ({1'b0, row_count_reg} < h_eff) ? row_count_reg : ROW_W'(h_eff - 1'b1);
    assign last_col_in = ({1'b0, x_in} == fwidth_t'(w_eff - 1'b1));
    assign last_row_in = ({1'b0, y_in} == fheight_t'(h_eff - 1'b1));

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_fire)
        begin
            if (last_col_in)
            begin
                col_count_next = '0;
                row_count_next = last_row_in ? '0 : row_t'(y_in + 1'b1);
            end
            else
            begin
                col_count_next = col_t'(x_in + 1'b1);
                row_count_next = y_in;
            end
        end
    end

    // Handshakes.
    assign set_free = (pend_reg == '0)
                   || (pix_out.ready && ((pend_reg & (pend_reg - 1'b1)) == '0));
    assign s1_adv   = s1_valid_reg && set_free;
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign in_fire  = pix_in.valid && pix_in.ready;
    assign out_fire = pix_out.valid && pix_out.ready;

    // Line stores: bit 0 holds row y-1, bit 1 row y-2.
    bdil_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_x_reg),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (x_in),
        .rd_data (rd_data)
    );

    // A one-pixel-wide frame reads the entry that the previous pixel writes in the same
    // cycle; that write is captured and used instead of the stale read.
    assign line_bits = byp_valid_reg ? byp_data_reg : rd_data;
    assign wr_data   = {line_bits[0], s1_cur_reg};
    assign col_bits  = {(s1_y_reg >= row_t'(2)) && line_bits[1],
                        (s1_y_reg != '0) && line_bits[0],
                        s1_cur_reg};

    always_comb
    begin
        if (s1_x_reg == '0)
            window_next = {6'b0, col_bits};
        else
            window_next = {window_reg[5:0], col_bits};

        new_mask[0] = (s1_y_reg != '0) && (s1_x_reg != '0);
        new_mask[1] = (s1_y_reg != '0) && s1_last_col_reg;
        new_mask[2] = s1_last_row_reg && (s1_x_reg != '0);
        new_mask[3] = s1_last_row_reg && s1_last_col_reg;

        new_on[0] = |(window_next & MASK_FULL);
        new_on[1] = |(window_next & MASK_RIGHT);
        new_on[2] = |(window_next & MASK_BOTTOM);
        new_on[3] = |(window_next & MASK_CORNER);
    end

    // Results leave in raster order of the output pixels: lowest pending bit first.
    always_comb
    begin
        priority if (pend_reg[0])
            sel = 2'd0;
        else if (pend_reg[1])
            sel = 2'd1;
        else if (pend_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        low_bit = 4'b0001 << sel;

        pend_next = pend_reg;
        if (s1_adv)
            pend_next = new_mask;
        else if (out_fire)
            pend_next = pend_reg & ~low_bit;
    end

    assign pix_out.valid     = (pend_reg != '0);
    assign pix_out.out_value = res_on_reg[sel] ? PIX_ON : PIX_OFF;
    assign pix_out.out_col   = sel[0] ? res_x_reg : col_t'(res_x_reg - 1'b1);
    assign pix_out.out_row   = sel[1] ? res_y_reg : row_t'(res_y_reg - 1'b1);
    assign pix_out.run_last  = ((pend_reg & ~low_bit) == '0);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            on_threshold_reg <= THRESHOLD_RST;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            byp_valid_reg    <= 1'b0;
            window_reg       <= '0;
            pend_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    REG_ON_THRESHOLD: on_threshold_reg <= cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (in_fire)
            begin
                s1_valid_reg  <= 1'b1;
                byp_valid_reg <= s1_adv && (s1_x_reg == x_in);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                window_reg <= window_next;
            end
            pend_reg <= pend_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cur_reg      <= (pix_in.grey_value > on_threshold_reg);
            s1_x_reg        <= x_in;
            s1_y_reg        <= y_in;
            s1_last_col_reg <= last_col_in;
            s1_last_row_reg <= last_row_in;
            byp_data_reg    <= wr_data;
        end
        if (s1_adv)
        begin
            res_on_reg <= new_on;
            res_x_reg  <= s1_x_reg;
            res_y_reg  <= s1_y_reg;
        end
    end
endmodule
